### src/eatrm_pkg.sv
// ============================================================================
// Euler angle to rotation matrix: shared types and constants
// Packed transfer types for the angle and matrix channels, the phase and
// sine/cosine types between the units, and the CORDIC arctangent table.
// ============================================================================
package eatrm_pkg;

    // Field widths fixed by the channel definitions.
    localparam int ANGLE_W = 16;
    localparam int ELEM_W  = 16;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
    } t_angles;

    typedef struct packed {
        logic signed [ELEM_W-1:0] r00;
        logic signed [ELEM_W-1:0] r01;
        logic signed [ELEM_W-1:0] r02;
        logic signed [ELEM_W-1:0] r10;
        logic signed [ELEM_W-1:0] r11;
        logic signed [ELEM_W-1:0] r12;
        logic signed [ELEM_W-1:0] r20;
        logic signed [ELEM_W-1:0] r21;
        logic signed [ELEM_W-1:0] r22;
    } t_matrix;

    // Binary angle of the residual: 2^30 is a quarter turn.
    localparam int Z_W    = 30;
    localparam int QUAD_W = 2;

    typedef struct packed {
        logic [QUAD_W-1:0] quad;
        logic [Z_W-1:0]    z;
    } t_phase;

    typedef struct packed {
        logic signed [ELEM_W-1:0] sin_v;
        logic signed [ELEM_W-1:0] cos_v;
    } t_sincos;

    localparam logic signed [ELEM_W-1:0] Q14_ONE = 16'sd16384;

    // CORDIC datapath: 2^30 is 1.0; the start value carries the gain.
    localparam int CORDIC_W    = 32;
    localparam int ATAN_DEPTH  = 24;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032874;

    localparam logic signed [CORDIC_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
    };

endpackage

### src/eatrm_angle_reduce.sv
// ============================================================================
// Angle reduction
// Splits a signed angle into a quadrant and a binary residual angle in three
// register stages, dividing by ninety through a reciprocal multiply.
// ============================================================================
module eatrm_angle_reduce #(
    parameter int ANGLE_FRACTION_BITS = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [eatrm_pkg::ANGLE_W-1:0] i_angle,
    output logic                               o_valid,
    output eatrm_pkg::t_phase                  o_phase
);
    import eatrm_pkg::*;

    // A whole turn in input units, and a multiple of it that lifts any
    // input to a non-negative value without changing it modulo a turn.
    localparam int FULL_TURN = 360 << ANGLE_FRACTION_BITS;
    localparam int OFFSET    = FULL_TURN * ((32768 + FULL_TURN - 1) / FULL_TURN);
    localparam int U_W       = 19;
    localparam int H_W       = 13;
    localparam int G_W       = 7;
    localparam int RECIP_SH  = 24;
    localparam int RECIP_W   = 18;
    localparam int PROD_W    = U_W + RECIP_W;
    localparam int ZSH       = Z_W - ANGLE_FRACTION_BITS;
    localparam int NINETY_I  = 90;
    localparam logic [RECIP_W-1:0] RECIP90 = RECIP_W'((1 << RECIP_SH) / NINETY_I);
    localparam logic [G_W-1:0]     NINETY  = G_W'(NINETY_I);

    // Binary angle of each residual below ninety input units.
    function automatic logic [NINETY_I-1:0][Z_W-1:0] build_ztab();
        logic [NINETY_I-1:0][Z_W-1:0] tab;
        logic [63:0]                  num;
        for (int g = 0; g < NINETY_I; g++) begin
            num    = 64'(g) << ZSH;
            tab[g] = Z_W'(num / 64'd90);
        end
        return tab;
    endfunction

    localparam logic [NINETY_I-1:0][Z_W-1:0] ZTAB = build_ztab();

    logic [U_W-1:0]    n_u;
    logic [PROD_W-1:0] n_prod;
    logic [U_W-1:0]    n_qm;
    logic [U_W-1:0]    n_g0;
    logic [H_W-1:0]    n_h;
    logic [G_W-1:0]    n_g;
    logic [Z_W+H_W-1:0] n_hs;
    logic [H_W-1:0]    n_hq;
    t_phase            n_phase;

    logic              r_va, r_vb, r_vc;
    logic [U_W-1:0]    r_u;
    logic [H_W-1:0]    r_q0;
    logic [H_W-1:0]    r_h;
    logic [G_W-1:0]    r_g;
    t_phase            r_phase;

    always_comb begin
        n_u    = U_W'(int'(i_angle) + OFFSET);
        n_prod = PROD_W'(n_u) * PROD_W'(RECIP90);
        n_qm   = U_W'(r_q0) * U_W'(NINETY);
        n_g0   = r_u - n_qm;
        if (n_g0 >= U_W'(NINETY)) begin
            n_h = r_q0 + H_W'(1);
            n_g = G_W'(n_g0 - U_W'(NINETY));
        end else begin
            n_h = r_q0;
            n_g = G_W'(n_g0);
        end
        n_hs          = (Z_W+H_W)'(r_h) << ZSH;
        n_hq          = r_h >> ANGLE_FRACTION_BITS;
        n_phase.quad  = n_hq[QUAD_W-1:0];
        n_phase.z     = n_hs[Z_W-1:0] | ZTAB[r_g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
        r_u     <= n_u;
        r_q0    <= n_prod[RECIP_SH +: H_W];
        r_h     <= n_h;
        r_g     <= n_g;
        r_phase <= n_phase;
    end

    assign o_valid = r_vc;
    assign o_phase = r_phase;

endmodule

### src/eatrm_cordic.sv
// ============================================================================
// Pipelined CORDIC rotator
// One register stage per iteration, then rounding to Q1.14 and the fold of
// sine and cosine back into the original quadrant.
// ============================================================================
module eatrm_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  eatrm_pkg::t_phase  i_phase,
    output logic               o_valid,
    output eatrm_pkg::t_sincos o_sincos
);
    import eatrm_pkg::*;

    localparam int LAST = CORDIC_STAGES - 1;

    logic                       r_v [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] r_x [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] r_y [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] r_z [CORDIC_STAGES];
    logic [QUAD_W-1:0]          r_q [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic                       v_in;
        logic signed [CORDIC_W-1:0] x_in, y_in, z_in;
        logic [QUAD_W-1:0]          q_in;
        logic signed [CORDIC_W-1:0] n_x, n_y, n_z;

        if (i == 0) begin : g_first
            assign v_in = i_valid;
            assign x_in = CORDIC_X0;
            assign y_in = '0;
            assign z_in = CORDIC_W'(i_phase.z);
            assign q_in = i_phase.quad;
        end else begin : g_next
            assign v_in = r_v[i-1];
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
            assign q_in = r_q[i-1];
        end

        always_comb begin
            if (z_in >= 0) begin
                n_x = x_in - (y_in >>> i);
                n_y = y_in + (x_in >>> i);
                n_z = z_in - ATAN_TAB[i];
            end else begin
                n_x = x_in + (y_in >>> i);
                n_y = y_in - (x_in >>> i);
                n_z = z_in + ATAN_TAB[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= v_in;
            end
            r_x[i] <= n_x;
            r_y[i] <= n_y;
            r_z[i] <= n_z;
            r_q[i] <= q_in;
        end
    end

    function automatic logic signed [ELEM_W-1:0] round_q14(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [CORDIC_W-1:0] t;
        logic signed [ELEM_W-1:0]   s;
        t = v + CORDIC_W'(32768);
        s = t[CORDIC_W-1 -: ELEM_W];
        if (s > Q14_ONE) begin
            return Q14_ONE;
        end else if (s < -Q14_ONE) begin
            return -Q14_ONE;
        end
        return s;
    endfunction

    logic signed [ELEM_W-1:0] n_c, n_s;
    t_sincos                  n_sincos;
    logic                     r_vo;
    t_sincos                  r_sincos;

    always_comb begin
        n_c = round_q14(r_x[LAST]);
        n_s = round_q14(r_y[LAST]);
        case (r_q[LAST])
            2'd0: begin
                n_sincos.cos_v = n_c;
                n_sincos.sin_v = n_s;
            end
            2'd1: begin
                n_sincos.cos_v = -n_s;
                n_sincos.sin_v = n_c;
            end
            2'd2: begin
                n_sincos.cos_v = -n_c;
                n_sincos.sin_v = -n_s;
            end
            default: begin
                n_sincos.cos_v = n_s;
                n_sincos.sin_v = -n_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_v[LAST];
        end
        r_sincos <= n_sincos;
    end

    assign o_valid  = r_vo;
    assign o_sincos = r_sincos;

endmodule

### src/eatrm_matrix.sv
// ============================================================================
// Matrix element pipeline
// Forms the nine elements of Rz * Ry * Rx from sines and cosines in four
// stages: pair products, triple products, sums, rounding with saturation.
// ============================================================================
module eatrm_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  eatrm_pkg::t_sincos i_yaw,
    input  eatrm_pkg::t_sincos i_pitch,
    input  eatrm_pkg::t_sincos i_roll,
    output logic               o_valid,
    output eatrm_pkg::t_matrix o_matrix
);
    import eatrm_pkg::*;

    localparam int P_W = 30;
    localparam int S_W = 45;
    localparam int N_E = 9;
    localparam logic signed [S_W-1:0] RND_HALF = S_W'(134217728);

    function automatic logic signed [P_W-1:0] mul2(
        input logic signed [ELEM_W-1:0] a,
        input logic signed [ELEM_W-1:0] b
    );
        logic signed [2*ELEM_W-1:0] p;
        p = (2*ELEM_W)'(a) * (2*ELEM_W)'(b);
        return P_W'(p);
    endfunction

    function automatic logic signed [S_W-1:0] mul3(
        input logic signed [P_W-1:0]    a,
        input logic signed [ELEM_W-1:0] b
    );
        logic signed [S_W-1:0] p;
        p = S_W'(a) * S_W'(b);
        return p;
    endfunction

    function automatic logic signed [S_W-1:0] scale14(input logic signed [P_W-1:0] a);
        logic signed [S_W-1:0] e;
        e = S_W'(a);
        return e <<< 14;
    endfunction

    // Stage 1: products of two factors.
    logic                     r_v1;
    logic signed [P_W-1:0]    r_czsy, r_szsy, r_czcy, r_szcy, r_szcx;
    logic signed [P_W-1:0]    r_szsx, r_czcx, r_czsx, r_cysx, r_cycx;
    logic signed [ELEM_W-1:0] r_sx1, r_cx1, r_sy1;
    logic signed [ELEM_W-1:0] n_sy;

    // Stage 2: the two terms of each element at 2^42 scale.
    logic                     r_v2;
    logic signed [S_W-1:0]    r_a [N_E];
    logic signed [S_W-1:0]    r_b [N_E];
    logic signed [S_W-1:0]    n_a [N_E];
    logic signed [S_W-1:0]    n_b [N_E];
    logic signed [S_W-1:0]    n_sy42;

    // Stage 3: sums.  Stage 4: rounding and saturation.
    logic                     r_v3;
    logic signed [S_W-1:0]    r_sum [N_E];
    logic signed [ELEM_W-1:0] n_e [N_E];
    logic                     r_v4;
    t_matrix                  r_out;

    assign n_sy = -i_roll.sin_v;

    always_ff @(posedge i_clk) begin
        r_czsy <= mul2(i_yaw.cos_v, n_sy);
        r_szsy <= mul2(i_yaw.sin_v, n_sy);
        r_czcy <= mul2(i_yaw.cos_v, i_roll.cos_v);
        r_szcy <= mul2(i_yaw.sin_v, i_roll.cos_v);
        r_szcx <= mul2(i_yaw.sin_v, i_pitch.cos_v);
        r_szsx <= mul2(i_yaw.sin_v, i_pitch.sin_v);
        r_czcx <= mul2(i_yaw.cos_v, i_pitch.cos_v);
        r_czsx <= mul2(i_yaw.cos_v, i_pitch.sin_v);
        r_cysx <= mul2(i_roll.cos_v, i_pitch.sin_v);
        r_cycx <= mul2(i_roll.cos_v, i_pitch.cos_v);
        r_sx1  <= i_pitch.sin_v;
        r_cx1  <= i_pitch.cos_v;
        r_sy1  <= n_sy;
    end

    always_comb begin
        n_sy42 = S_W'(r_sy1);
        n_a[0] = '0;
        n_b[0] = scale14(r_czcy);
        n_a[1] = mul3(r_czsy, r_sx1);
        n_b[1] = -scale14(r_szcx);
        n_a[2] = mul3(r_czsy, r_cx1);
        n_b[2] = scale14(r_szsx);
        n_a[3] = '0;
        n_b[3] = scale14(r_szcy);
        n_a[4] = mul3(r_szsy, r_sx1);
        n_b[4] = scale14(r_czcx);
        n_a[5] = mul3(r_szsy, r_cx1);
        n_b[5] = -scale14(r_czsx);
        n_a[6] = '0;
        n_b[6] = -(n_sy42 <<< 28);
        n_a[7] = '0;
        n_b[7] = scale14(r_cysx);
        n_a[8] = '0;
        n_b[8] = scale14(r_cycx);
    end

    always_comb begin
        for (int e = 0; e < N_E; e++) begin
            logic signed [S_W-1:0] t;
            t = (r_sum[e] + RND_HALF) >>> 28;
            if (t > Q14_ONE) begin
                n_e[e] = Q14_ONE;
            end else if (t < -Q14_ONE) begin
                n_e[e] = -Q14_ONE;
            end else begin
                n_e[e] = t[ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        for (int e = 0; e < N_E; e++) begin
            r_a[e]   <= n_a[e];
            r_b[e]   <= n_b[e];
            r_sum[e] <= r_a[e] + r_b[e];
        end
        r_out.r00 <= n_e[0];
        r_out.r01 <= n_e[1];
        r_out.r02 <= n_e[2];
        r_out.r10 <= n_e[3];
        r_out.r11 <= n_e[4];
        r_out.r12 <= n_e[5];
        r_out.r20 <= n_e[6];
        r_out.r21 <= n_e[7];
        r_out.r22 <= n_e[8];
    end

    assign o_valid  = r_v4;
    assign o_matrix = r_out;

endmodule

### src/euler_angles_to_rotation_matrix.sv
// ============================================================================
// Euler angles to rotation matrix
// Turns yaw, pitch and roll into the ZYX rotation matrix in Q1.14.
// ============================================================================
// Usage. An attitude sample is presented on i_angles together with start; the
// transfer takes place at the rising edge at which start is high and busy is
// low. Angles are signed degrees with ANGLE_FRACTION_BITS fraction bits and
// wrap modulo a full turn, so every bit pattern is a valid angle.
// The matrix R = Rz(yaw) * Ry(-roll) * Rx(pitch) appears on o_matrix for one
// cycle, marked by o_valid; the receiver takes it at the edge that ends that
// cycle and cannot hold it off, so nothing in the block ever waits on it.
// Throughput is one sample per clock: the three angle paths and the matrix
// stage are fully pipelined, and busy stays low outside reset.
// The sample passes through three registers of angle reduction, one per CORDIC
// iteration, one for rounding and the quadrant fold, and four in the element
// pipeline; the first of these loads at the accepting edge itself.
// Reset (synchronous, active low) clears every valid bit, so no result
// leaves the block for samples in flight; busy is high during reset and stays
// high until the first clock edge at which reset is seen released.
// ============================================================================
module euler_angles_to_rotation_matrix #(
    parameter int CORDIC_STAGES       = 16,
    parameter int ANGLE_FRACTION_BITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  eatrm_pkg::t_angles i_angles,
    output logic               o_valid,
    output eatrm_pkg::t_matrix o_matrix
);
    import eatrm_pkg::*;

    logic    r_busy;
    logic    w_accept;

    logic    w_yaw_pv, w_pitch_pv, w_roll_pv;
    t_phase  w_yaw_ph, w_pitch_ph, w_roll_ph;
    logic    w_yaw_sv, w_pitch_sv, w_roll_sv;
    t_sincos w_yaw_sc, w_pitch_sc, w_roll_sc;

    // Busy only guards the cycles around reset; the pipeline itself never
    // refuses a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start & ~r_busy;

    // Each angle goes through its own reduction and CORDIC pipeline; all
    // three run in lock step, so their valid bits always agree.
    eatrm_angle_reduce #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_red_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_angle (i_angles.yaw_angle),
        .o_valid (w_yaw_pv),
        .o_phase (w_yaw_ph)
    );

    eatrm_angle_reduce #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_red_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_angle (i_angles.pitch_angle),
        .o_valid (w_pitch_pv),
        .o_phase (w_pitch_ph)
    );

    eatrm_angle_reduce #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_red_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_angle (i_angles.roll_angle),
        .o_valid (w_roll_pv),
        .o_phase (w_roll_ph)
    );

    eatrm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_yaw (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_yaw_pv),
        .i_phase  (w_yaw_ph),
        .o_valid  (w_yaw_sv),
        .o_sincos (w_yaw_sc)
    );

    eatrm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_pitch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_pitch_pv),
        .i_phase  (w_pitch_ph),
        .o_valid  (w_pitch_sv),
        .o_sincos (w_pitch_sc)
    );

    eatrm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_roll (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_roll_pv),
        .i_phase  (w_roll_ph),
        .o_valid  (w_roll_sv),
        .o_sincos (w_roll_sc)
    );

    // The element pipeline ends in the output register that drives o_matrix.
    eatrm_matrix u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_yaw_sv & w_pitch_sv & w_roll_sv),
        .i_yaw    (w_yaw_sc),
        .i_pitch  (w_pitch_sc),
        .i_roll   (w_roll_sc),
        .o_valid  (o_valid),
        .o_matrix (o_matrix)
    );

endmodule
